// ===== hw/rtl/tcag_pkg.sv =====
package tcag_pkg;

  localparam int MAX_DIMS_DEF    = 4;
  localparam int EXTENT_BITS_DEF = 12;

  localparam int REG_W    = 48;   // packed config and result words
  localparam int CHUNK_W  = 32;   // chunk number width
  localparam int NDIM_W   = 3;    // num_dims register width
  localparam int TOTAL_W  = 34;   // saturating chunk total
  localparam int CAP_BIT  = 33;   // total saturates at 2**CAP_BIT
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHAPES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZES    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_BADCFG = 2'd2;

  // setup sequencer states
  typedef enum logic [5:0] {
    SU_IDLE = 6'b000001,
    SU_LDM  = 6'b000010,
    SU_MOD  = 6'b000100,
    SU_LDC  = 6'b001000,
    SU_CNT  = 6'b010000,
    SU_MUL  = 6'b100000
  } setup_state_t;

  // configuration summary handed to the datapath
  typedef struct packed {
    logic                busy;
    logic                bad;
    logic [NDIM_W-1:0]   num_dims;
    logic [TOTAL_W-1:0]  total;
  } cfg_stat_t;

endpackage

// ===== hw/rtl/tcag_setup.sv =====
module tcag_setup
  import tcag_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  output cfg_stat_t              stat,
  output logic [EXTENT_BITS-1:0] off_f [MAX_DIMS],
  output logic [EXTENT_BITS-1:0] shp_f [MAX_DIMS],
  output logic [EXTENT_BITS-1:0] ts_f  [MAX_DIMS],
  output logic [EXTENT_BITS-1:0] rem_f [MAX_DIMS],
  output logic [EXTENT_BITS-1:0] cnt_f [MAX_DIMS]
);

  localparam int EB  = EXTENT_BITS;
  localparam int NW  = EB + 2;
  localparam int BCW = $clog2(NW);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW  = TOTAL_W + EB;
  localparam logic [EB-1:0]      FIELD_MAX = {EB{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(1) << CAP_BIT;

  logic [NDIM_W-1:0]  num_dims;
  logic [REG_W-1:0]   block_offsets;
  logic [REG_W-1:0]   block_shapes;
  logic [REG_W-1:0]   tile_sizes;

  setup_state_t       state;
  logic [DW-1:0]      didx;
  logic [BCW-1:0]     bc;
  logic [NW-1:0]      dvd;
  logic [EB-1:0]      rr;
  logic [EB-1:0]      rem_r [MAX_DIMS];
  logic [EB-1:0]      cnt_r [MAX_DIMS];
  logic [TOTAL_W-1:0] total;

  logic [EB:0]        sh;
  logic               ge;
  logic [EB:0]        nr;
  logic [NW-1:0]      dvd_next;
  logic [PW-1:0]      prod;
  logic               bad;

  // field extraction, zero beyond the register
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_field
    logic [63:0] so, ss, st;
    assign so = {{(64-REG_W){1'b0}}, block_offsets} >> (d*EB);
    assign ss = {{(64-REG_W){1'b0}}, block_shapes} >> (d*EB);
    assign st = {{(64-REG_W){1'b0}}, tile_sizes} >> (d*EB);
    assign off_f[d] = so[EB-1:0];
    assign shp_f[d] = ss[EB-1:0];
    assign ts_f[d]  = st[EB-1:0];
    assign rem_f[d] = rem_r[d];
    // dimensions past num_dims count as radix one
    assign cnt_f[d] = (d >= int'(num_dims)) ? EB'(1) : cnt_r[d];
  end

  always_comb begin
    bad = (num_dims == '0) || (int'(num_dims) > MAX_DIMS);
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < int'(num_dims)) begin
        if (ts_f[d] == '0 || ({1'b0, off_f[d]} + {1'b0, shp_f[d]}) > {1'b0, FIELD_MAX}) begin
          bad = 1'b1;
        end
      end
    end
  end

  // restoring divider step, one bit a cycle
  assign sh       = {rr, dvd[NW-1]};
  assign ge       = sh >= {1'b0, ts_f[didx]};
  assign nr       = ge ? (sh - {1'b0, ts_f[didx]}) : sh;
  assign dvd_next = {dvd[NW-2:0], ge};
  assign prod     = PW'(total) * PW'(cnt_f[didx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims      <= NDIM_W'(1);
      block_offsets <= '0;
      block_shapes  <= '0;
      tile_sizes    <= '0;
      state         <= SU_LDM;
      didx          <= '0;
      total         <= TOTAL_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_DIMS:      num_dims      <= cfg_data[NDIM_W-1:0];
        REG_BLOCK_OFFSETS: block_offsets <= cfg_data;
        REG_BLOCK_SHAPES:  block_shapes  <= cfg_data;
        REG_TILE_SIZES:    tile_sizes    <= cfg_data;
        default: ;
      endcase
      state <= SU_LDM;
      didx  <= '0;
      total <= TOTAL_W'(1);
    end else begin
      unique case (state)
        SU_IDLE: ;
        SU_LDM: begin
          dvd   <= NW'(off_f[didx]);
          rr    <= '0;
          bc    <= '0;
          state <= SU_MOD;
        end
        SU_MOD: begin
          dvd <= dvd_next;
          rr  <= nr[EB-1:0];
          bc  <= bc + BCW'(1);
          if (bc == BCW'(NW-1)) begin
            rem_r[didx] <= nr[EB-1:0];
            state       <= SU_LDC;
          end
        end
        SU_LDC: begin
          dvd   <= NW'(rem_r[didx]) + NW'(shp_f[didx]) + NW'(ts_f[didx]) - NW'(1);
          rr    <= '0;
          bc    <= '0;
          state <= SU_CNT;
        end
        SU_CNT: begin
          dvd <= dvd_next;
          rr  <= nr[EB-1:0];
          bc  <= bc + BCW'(1);
          if (bc == BCW'(NW-1)) begin
            cnt_r[didx] <= (shp_f[didx] == '0) ? '0 : dvd_next[EB-1:0];
            state       <= SU_MUL;
          end
        end
        SU_MUL: begin
          total <= (prod > PW'(TOTAL_CAP)) ? TOTAL_CAP : prod[TOTAL_W-1:0];
          if (didx == DW'(MAX_DIMS-1)) begin
            state <= SU_IDLE;
          end else begin
            didx  <= didx + DW'(1);
            state <= SU_LDM;
          end
        end
        default: state <= SU_IDLE;
      endcase
    end
  end

  assign stat.busy     = (state != SU_IDLE);
  assign stat.bad      = bad;
  assign stat.num_dims = num_dims;
  assign stat.total    = total;

endmodule

// ===== hw/rtl/tcag_radix.sv =====
module tcag_radix
  import tcag_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [CHUNK_W-1:0]     chunk,
  input  logic [1:0]             status_in,
  input  logic [EXTENT_BITS-1:0] cnt [MAX_DIMS],
  output logic                   out_valid,
  output logic [EXTENT_BITS-1:0] out_ids [MAX_DIMS],
  output logic [1:0]             out_status
);

  localparam int EB = EXTENT_BITS;
  localparam int CW = CHUNK_W;
  localparam int NS = MAX_DIMS * CW;

  logic               vld [0:NS];
  logic [1:0]         st  [0:NS];
  logic [EB-1:0]      ids [0:NS][MAX_DIMS];
  logic [CW-1:0]      dq  [0:NS-1];
  logic [EB-1:0]      rm  [0:NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NS; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 0; j < NS; j++) vld[j+1] <= vld[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= status_in;
      dq[0] <= chunk;
      rm[0] <= '0;
      for (int d = 0; d < MAX_DIMS; d++) ids[0][d] <= '0;
    end
  end

  // last dimension first; one quotient bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int  DIM  = MAX_DIMS - 1 - (j / CW);
    localparam bit  LAST = ((j % CW) == CW - 1);
    logic [EB:0]    sh;
    logic           ge;
    logic [EB:0]    nr;

    assign sh = {rm[j], dq[j][CW-1]};
    assign ge = sh >= {1'b0, cnt[DIM]};
    assign nr = ge ? (sh - {1'b0, cnt[DIM]}) : sh;

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1] <= st[j];
        for (int d = 0; d < MAX_DIMS; d++)
          ids[j+1][d] <= (LAST && d == DIM) ? nr[EB-1:0] : ids[j][d];
      end
    end

    if (j < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dq[j+1] <= {dq[j][CW-2:0], ge};
          rm[j+1] <= LAST ? '0 : nr[EB-1:0];
        end
      end
    end
  end

  assign out_valid  = vld[NS];
  assign out_status = st[NS];
  assign out_ids    = ids[NS];

endmodule

// ===== hw/rtl/tcag_place.sv =====
module tcag_place
  import tcag_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [EXTENT_BITS-1:0] ids [MAX_DIMS],
  input  logic [1:0]             status_in,
  input  logic [NDIM_W-1:0]      num_dims,
  input  logic [EXTENT_BITS-1:0] off_f [MAX_DIMS],
  input  logic [EXTENT_BITS-1:0] shp_f [MAX_DIMS],
  input  logic [EXTENT_BITS-1:0] ts_f  [MAX_DIMS],
  input  logic [EXTENT_BITS-1:0] rem_f [MAX_DIMS],
  output logic                   out_valid,
  output logic [REG_W-1:0]       read_offsets,
  output logic [REG_W-1:0]       write_offsets,
  output logic [REG_W-1:0]       tile_extents,
  output logic                   is_partial,
  output logic [1:0]             status
);

  localparam int EB = EXTENT_BITS;
  localparam int XW = 2 * EB + 2;

  logic               v1;
  logic [1:0]         st1;
  logic [EB-1:0]      id1   [MAX_DIMS];
  logic [2*EB-1:0]    prod1 [MAX_DIMS];

  logic [63:0]        rd_acc, wr_acc, ex_acc;
  logic               part;

  // stage 1: tile base within block, ts * id
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= status_in;
      for (int d = 0; d < MAX_DIMS; d++) begin
        id1[d]   <= ids[d];
        prod1[d] <= (2*EB)'(ts_f[d]) * (2*EB)'(ids[d]);
      end
    end
  end

  // stage 2: clip and pack
  always_comb begin
    logic          act, left, right;
    logic [XW-1:0] tsid, start, rdv, sz, endr;
    rd_acc = '0;
    wr_acc = '0;
    ex_acc = '0;
    part   = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      act   = (d < int'(num_dims)) && (st1 == ST_OK);
      tsid  = XW'(prod1[d]);
      left  = (id1[d] == '0) && (rem_f[d] != '0);
      start = left ? XW'(off_f[d]) : XW'(off_f[d]) - XW'(rem_f[d]) + tsid;
      rdv   = left ? '0 : tsid - XW'(rem_f[d]);
      endr  = XW'(ts_f[d]) - XW'(rem_f[d]) + tsid;
      right = endr > XW'(shp_f[d]);
      sz    = left ? XW'(ts_f[d]) - XW'(rem_f[d]) : XW'(ts_f[d]);
      if (right) sz = sz - (endr - XW'(shp_f[d]));
      if (act) begin
        rd_acc = rd_acc | (64'(rdv[EB-1:0]) << (d*EB));
        wr_acc = wr_acc | (64'(start[EB-1:0]) << (d*EB));
        ex_acc = ex_acc | (64'(sz[EB-1:0]) << (d*EB));
        part   = part | left | right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      read_offsets  <= rd_acc[REG_W-1:0];
      write_offsets <= wr_acc[REG_W-1:0];
      tile_extents  <= ex_acc[REG_W-1:0];
      is_partial    <= part;
      status        <= st1;
    end
  end

endmodule

// ===== hw/rtl/tiled_chunk_address_generator.sv =====
// Tiled chunk address generator.
// Configuration: write channel cfg_valid/cfg_ready with cfg_index and
// cfg_data (num_dims, block_offsets, block_shapes, tile_sizes). cfg_ready
// is always high. Every write, and reset, starts a setup pass that works out
// each dimension's offset remainder and tile count and the total chunk count
// with a shared one-bit-a-cycle divider. s_tready stays low during that pass.
// Input: s_tvalid/s_tready/s_tdata carries one chunk number per transfer.
// Output: m_tvalid/m_tready/m_tdata/m_tuser carries one descriptor per input.
// Throughput is one transfer per cycle while the output queue has room and
// no setup pass runs. The mixed-radix split is a restoring divide, one
// quotient bit per stage.
// A two-entry output queue takes results while m_tready is low; the pipeline
// halts only when both entries are full, so nothing is lost or repeated.
// Reset empties the pipeline and queue and restores register defaults.
module tiled_chunk_address_generator
  import tcag_pkg::*;
#(
  parameter int MAX_DIMS    = MAX_DIMS_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHUNK_W-1:0]    s_tdata,  // chunk_number
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [3*REG_W-1:0]    m_tdata,  // read_offsets, write_offsets, tile_extents
  output logic [2:0]            m_tuser   // is_partial, status[1:0]
);

  localparam int EB = EXTENT_BITS;
  localparam int OW = 3 * REG_W + 3;

  cfg_stat_t       cs;
  logic [EB-1:0]   off_f [MAX_DIMS];
  logic [EB-1:0]   shp_f [MAX_DIMS];
  logic [EB-1:0]   ts_f  [MAX_DIMS];
  logic [EB-1:0]   rem_f [MAX_DIMS];
  logic [EB-1:0]   cnt_f [MAX_DIMS];

  logic            en;
  logic [1:0]      status_in;
  logic            rx_valid;
  logic [EB-1:0]   rx_ids [MAX_DIMS];
  logic [1:0]      rx_status;

  logic            pv;
  logic [REG_W-1:0] p_rd, p_wr, p_ex;
  logic            p_part;
  logic [1:0]      p_st;
  logic [OW-1:0]   p_word;

  // output queue
  logic [OW-1:0]   slot0, slot1;
  logic [1:0]      fcnt;
  logic            push, take;

  assign cfg_ready = 1'b1;

  tcag_setup #(.MAX_DIMS(MAX_DIMS), .EXTENT_BITS(EXTENT_BITS)) u_setup (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .stat(cs), .off_f, .shp_f, .ts_f, .rem_f, .cnt_f
  );

  // pipeline moves whenever the output queue has room
  assign en       = (fcnt != 2'd2);
  assign s_tready = en && !cs.busy;

  // bad config wins over range check
  always_comb begin
    if (cs.bad)                               status_in = ST_BADCFG;
    else if (TOTAL_W'(s_tdata) >= cs.total)   status_in = ST_RANGE;
    else                                      status_in = ST_OK;
  end

  tcag_radix #(.MAX_DIMS(MAX_DIMS), .EXTENT_BITS(EXTENT_BITS)) u_radix (
    .clk, .rst, .en,
    .in_valid(s_tvalid && s_tready),
    .chunk(s_tdata),
    .status_in,
    .cnt(cnt_f),
    .out_valid(rx_valid),
    .out_ids(rx_ids),
    .out_status(rx_status)
  );

  tcag_place #(.MAX_DIMS(MAX_DIMS), .EXTENT_BITS(EXTENT_BITS)) u_place (
    .clk, .rst, .en,
    .in_valid(rx_valid),
    .ids(rx_ids),
    .status_in(rx_status),
    .num_dims(cs.num_dims),
    .off_f, .shp_f, .ts_f, .rem_f,
    .out_valid(pv),
    .read_offsets(p_rd),
    .write_offsets(p_wr),
    .tile_extents(p_ex),
    .is_partial(p_part),
    .status(p_st)
  );

  assign p_word = {p_st, p_part, p_ex, p_wr, p_rd};
  assign push   = pv && en;
  assign take   = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= 2'd0;
    end else begin
      fcnt <= fcnt + 2'(push) - 2'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !take) begin
      if (fcnt == 2'd0) slot0 <= p_word;
      else              slot1 <= p_word;
    end else if (take && !push) begin
      slot0 <= slot1;
    end else if (take && push) begin
      if (fcnt == 2'd1) begin
        slot0 <= p_word;
      end else begin
        slot0 <= slot1;
        slot1 <= p_word;
      end
    end
  end

  assign m_tvalid = (fcnt != 2'd0);
  assign m_tdata  = slot0[3*REG_W-1:0];
  assign m_tuser  = slot0[OW-1:3*REG_W];

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import tcag_pkg::*;

  typedef struct {
    logic [REG_W-1:0] rd_offs;
    logic [REG_W-1:0] wr_offs;
    logic [REG_W-1:0] extents;
    logic             partial;
    logic [1:0]       status;
  } tile_desc_t;

  // Holds the register image and the descriptors still owed by the block.
  class tile_scoreboard;
    logic [NDIM_W-1:0] ndims = 3'd1;
    logic [REG_W-1:0]  offs  = '0;
    logic [REG_W-1:0]  shps  = '0;
    logic [REG_W-1:0]  tiles = '0;
    tile_desc_t        owed[$];
    int                errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_NUM_DIMS:      ndims = val[NDIM_W-1:0];
        REG_BLOCK_OFFSETS: offs  = val;
        REG_BLOCK_SHAPES:  shps  = val;
        REG_TILE_SIZES:    tiles = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] fld(logic [REG_W-1:0] r, int d);
      return 64'(r[d*12 +: 12]);
    endfunction

    // Status of the current setup and, when usable, the chunk count.
    function logic [1:0] setup_check(output logic [63:0] cnt[4], output logic [63:0] total);
      logic [63:0] o, s, t;
      total = 1;
      for (int d = 0; d < 4; d++) cnt[d] = 0;
      if (ndims == 0 || ndims > 4) return ST_BADCFG;
      for (int d = 0; d < ndims; d++) begin
        o = fld(offs, d);
        s = fld(shps, d);
        t = fld(tiles, d);
        if (t == 0 || o + s > 4095) return ST_BADCFG;
        cnt[d] = (s == 0) ? 0 : ((o % t) + s + t - 1) / t;
        total = total * cnt[d];
        if (total > (64'd1 << CAP_BIT)) total = 64'd1 << CAP_BIT;
      end
      return ST_OK;
    endfunction

    function tile_desc_t descriptor(logic [CHUNK_W-1:0] chunk);
      tile_desc_t  e;
      logic [63:0] cnt[4];
      logic [63:0] total, c, o, s, t, id, start, size, end_rel;
      e = '{default: '0};
      e.status = setup_check(cnt, total);
      c = 64'(chunk);
      if (e.status == ST_OK && c >= total) e.status = ST_RANGE;
      if (e.status != ST_OK) return e;
      // last dimension varies fastest
      for (int d = ndims - 1; d >= 0; d--) begin
        o = fld(offs, d);
        s = fld(shps, d);
        t = fld(tiles, d);
        id = c % cnt[d];
        c = c / cnt[d];
        start = (o / t) * t + t * id;
        size = t;
        end_rel = (t - o % t) + id * t;
        if (start < o) begin
          e.partial = 1'b1;
          size = t - (o - start);
          start = o;
        end
        if (end_rel > s) begin
          e.partial = 1'b1;
          size = size - (end_rel - s);
        end
        e.rd_offs[d*12 +: 12] = 12'(start - o);
        e.wr_offs[d*12 +: 12] = 12'(start);
        e.extents[d*12 +: 12] = 12'(size);
      end
      return e;
    endfunction

    function void note_chunk(logic [CHUNK_W-1:0] chunk);
      owed.push_back(descriptor(chunk));
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_desc(logic [3*REG_W-1:0] data, logic [2:0] user);
      tile_desc_t e;
      if (owed.size() == 0) begin
        report("descriptor with none outstanding");
        return;
      end
      e = owed.pop_front();
      if (data[REG_W-1:0] !== e.rd_offs)
        report($sformatf("read offsets %h, want %h", data[REG_W-1:0], e.rd_offs));
      if (data[2*REG_W-1:REG_W] !== e.wr_offs)
        report($sformatf("write offsets %h, want %h", data[2*REG_W-1:REG_W], e.wr_offs));
      if (data[3*REG_W-1:2*REG_W] !== e.extents)
        report($sformatf("extents %h, want %h", data[3*REG_W-1:2*REG_W], e.extents));
      if (user[0] !== e.partial)
        report($sformatf("partial flag %b, want %b", user[0], e.partial));
      if (user[2:1] !== e.status)
        report($sformatf("status %0d, want %0d", user[2:1], e.status));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NUM_DIMS;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CHUNK_W-1:0]   s_tdata = '0;    // chunk_number
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [3*REG_W-1:0]   m_tdata;         // read_offsets, write_offsets, tile_extents
  logic [2:0]           m_tuser;         // is_partial, status[1:0]

  tile_scoreboard sb = new();
  bit  no_idle = 1'b0;                   // suppresses random gaps on both sides
  bit  sink_hold = 1'b0;                 // long receiver stall
  int  n_chunks = 0, n_descs = 0, n_writes = 0, quiet = 0;

  always #6 clk = ~clk;

  tiled_chunk_address_generator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Receiver: random back-pressure, none during the no-idle stretch.
  always @(negedge clk) begin
    m_tready <= !sink_hold && (no_idle || $urandom_range(99) >= 6);
  end

  // Monitor: every transfer is sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        n_writes++;
      end
      if (s_tvalid && s_tready) begin
        sb.note_chunk(s_tdata);
        n_chunks++;
      end
      if (m_tvalid && m_tready) begin
        sb.check_desc(m_tdata, m_tuser);
        n_descs++;
      end
    end
  end

  // Watchdog: setup passes, pipeline latency and the long stall fit well inside.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 4000) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Only while idle: wait for every descriptor, then past the pipeline depth.
  task automatic setup(logic [2:0] nd, logic [REG_W-1:0] o, logic [REG_W-1:0] s,
                       logic [REG_W-1:0] t);
    idle_sender();
    drain();
    repeat (140) @(posedge clk);
    write_reg(REG_NUM_DIMS, REG_W'(nd));
    write_reg(REG_BLOCK_OFFSETS, o);
    write_reg(REG_BLOCK_SHAPES, s);
    write_reg(REG_TILE_SIZES, t);
  endtask

  // Offers one chunk; valid stays high into the next item unless a gap is drawn.
  task automatic send_chunk(logic [CHUNK_W-1:0] c);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pack4(int a, int b, int c, int d);
    return {12'(d), 12'(c), 12'(b), 12'(a)};
  endfunction

  // Legal setup with mostly small tile counts; inactive fields get junk.
  task automatic random_setup();
    logic [REG_W-1:0] o, s, t;
    int nd, ov, lim, sv, tv;
    nd = $urandom_range(1, 4);
    for (int d = 0; d < 4; d++) begin
      tv = ($urandom_range(9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 12);
      ov = $urandom_range(0, 4095);
      lim = 4095 - ov;
      if (lim == 0) sv = 0;
      else if ($urandom_range(9) == 0) sv = $urandom_range(0, lim);
      else sv = $urandom_range(1, (lim < 40) ? lim : 40);
      if (d >= nd) begin
        tv = $urandom_range(0, 4095);
        sv = $urandom_range(0, 4095);
      end
      o[d*12 +: 12] = 12'(ov);
      s[d*12 +: 12] = 12'(sv);
      t[d*12 +: 12] = 12'(tv);
    end
    setup(3'(nd), o, s, t);
  endtask

  // Mostly chunks within or just past the total; some full-width values.
  function automatic logic [CHUNK_W-1:0] pick_chunk();
    logic [63:0] cnt[4];
    logic [63:0] total;
    logic [1:0]  st;
    st = sb.setup_check(cnt, total);
    if (st != ST_OK || $urandom_range(9) == 0) return $urandom();
    if (total > 64'hFFFF_FFF0) total = 64'hFFFF_FFF0;
    return CHUNK_W'($urandom_range(0, 32'(total) + 2));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset setup has zero tile sizes
    send_chunk(32'd0);
    send_chunk(32'hFFFF_FFFF);
    // one full-width tile
    setup(3'd1, pack4(0, 0, 0, 0), pack4(4095, 0, 0, 0), pack4(4095, 0, 0, 0));
    send_chunk(32'd0);
    send_chunk(32'd1);
    // four dims, clipped on both sides, 81 chunks
    setup(3'd4, pack4(5, 5, 5, 5), pack4(10, 10, 10, 10), pack4(4, 4, 4, 4));
    send_chunk(32'd0);
    send_chunk(32'd40);
    send_chunk(32'd80);
    send_chunk(32'd81);
    // unit tiles in the first dimension
    setup(3'd2, pack4(0, 4095, 0, 0), pack4(3, 0, 0, 0), pack4(1, 1, 0, 0));
    send_chunk(32'd2);
    setup(3'd2, pack4(0, 7, 0, 0), pack4(3, 4088, 0, 0), pack4(1, 4095, 0, 0));
    send_chunk(32'd0);
    send_chunk(32'd5);
    // empty block dimension: every chunk out of range
    setup(3'd3, pack4(4095, 1, 1, 0), pack4(0, 2, 2, 0), pack4(7, 1, 1, 0));
    send_chunk(32'd0);
    // illegal setups: dim count zero and too high, zero tile, overflowing extent
    setup(3'd0, pack4(1, 1, 1, 1), pack4(4, 4, 4, 4), pack4(2, 2, 2, 2));
    send_chunk(32'd0);
    idle_sender();
    drain();
    write_reg(REG_NUM_DIMS, REG_W'(5));
    send_chunk(32'd0);
    idle_sender();
    drain();
    write_reg(REG_NUM_DIMS, REG_W'(7));
    send_chunk(32'd0);
    setup(3'd2, pack4(1, 1, 0, 0), pack4(4, 4, 0, 0), pack4(2, 0, 0, 0));
    send_chunk(32'd0);
    setup(3'd1, pack4(4000, 0, 0, 0), pack4(96, 0, 0, 0), pack4(8, 0, 0, 0));
    send_chunk(32'd0);
    setup(3'd4, {4{12'hFFF}}, {4{12'h000}}, {4{12'hFFF}});
    send_chunk(32'd0);
    idle_sender();

    // random phases; the stalled phase offers more than the pipeline holds
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 9)
        setup(3'($urandom_range(1, 4)), {$urandom(), 16'($urandom())},
              {$urandom(), 16'($urandom())}, {$urandom(), 16'($urandom())});
      else
        random_setup();
      no_idle = (ph == 5);
      if (ph == 3)
        fork
          begin
            sink_hold = 1'b1;
            repeat (400) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      for (int i = 0; i < ((ph == 3) ? 200 : 120); i++) begin
        if (ph == 7 && i == 60) begin
          idle_sender();
          drain();
        end
        send_chunk(pick_chunk());
      end
      idle_sender();
      no_idle = 1'b0;
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.owed.size() != 0) sb.report("descriptors never delivered");
    $display("covered %0d chunk requests, %0d descriptors, %0d register writes",
             n_chunks, n_descs, n_writes);
    $display("setups: legal, clipped, empty, illegal dim counts, zero tiles, overflow");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tcag_pkg.sv
hw/rtl/tcag_setup.sv
hw/rtl/tcag_radix.sv
hw/rtl/tcag_place.sv
hw/rtl/tiled_chunk_address_generator.sv
tb/tb_top.sv
